// ===== hw/rtl/mnf_pkg.sv =====
// Package: shared constants, payload structs and codes for median normalization factors.
`default_nettype none
package mnf_pkg;

    localparam int MAX_GROUPS        = 8;
    localparam int SAMPLES_PER_GROUP = 1024;
    localparam int GW  = $clog2(MAX_GROUPS);          // group index bits
    localparam int NGW = $clog2(MAX_GROUPS + 1);      // group count bits
    localparam int IW  = $clog2(SAMPLES_PER_GROUP);   // sample index bits
    localparam int CW  = $clog2(SAMPLES_PER_GROUP + 1);
    localparam int AW  = GW + IW;                     // sample store address bits
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int DIVW   = 48;                       // dividend bits (Q16.16 shift)

    // request codes
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_COMPUTE = 2'd1;
    localparam logic [1:0] REQ_SCALE   = 2'd2;

    // result kinds
    localparam logic KIND_FACTOR = 1'b0;
    localparam logic KIND_SCALE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_NOMED = 2'd2;
    localparam logic [1:0] ST_DROP  = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_GROUPS = 2'd0;
    localparam logic [1:0] CFG_REF    = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_SCALE   = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  group_index;
        logic [31:0] intensity;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [2:0]  out_group;
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic [GW-1:0] grp;
        logic [31:0] data;
    } t_qentry;

    typedef struct packed {
        logic [NGW-1:0] ng;
        logic [GW-1:0]  ref_grp;
    } t_cfg;

    typedef struct packed {
        logic            start;
        logic [DIVW-1:0] dividend;
        logic [31:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DIVW-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== hw/rtl/mnf_queue.sv =====
// Module: short queue between the front and the back.
`default_nettype none
module mnf_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mnf_pkg::t_qentry  i_entry,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output mnf_pkg::t_qentry       o_entry
);

    mnf_pkg::t_qentry r_mem [mnf_pkg::QDEPTH];
    logic [mnf_pkg::QAW-1:0] r_wp, r_rp;
    logic [mnf_pkg::QAW:0]   r_cnt;
    logic w_push, w_pop;

    assign o_full  = (r_cnt == (mnf_pkg::QAW+1)'(mnf_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            if (w_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mnf_front.sv =====
// Module: front end: configuration registers, input transfer and request classification.
`default_nettype none
module mnf_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [3:0]        i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire mnf_pkg::t_in_item i_item,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output mnf_pkg::t_qentry       o_entry,
    output mnf_pkg::t_cfg          o_cfg
);

    logic [3:0] r_groups;
    logic [2:0] r_ref;
    logic [mnf_pkg::NGW-1:0] w_ng;
    logic w_take;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups <= 4'd8;
            r_ref    <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mnf_pkg::CFG_GROUPS: r_groups <= i_cfg_data;
                mnf_pkg::CFG_REF:    r_ref    <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamp the group count into one to MAX_GROUPS
    always_comb begin
        if (r_groups == 4'd0) w_ng = mnf_pkg::NGW'(1);
        else if (r_groups > 4'(mnf_pkg::MAX_GROUPS)) w_ng = mnf_pkg::NGW'(mnf_pkg::MAX_GROUPS);
        else w_ng = r_groups[mnf_pkg::NGW-1:0];
    end

    assign o_cfg.ng      = w_ng;
    assign o_cfg.ref_grp = r_ref;
    assign o_ready       = !i_q_full;
    assign w_take        = i_valid && o_ready;

    // classify: drop loads outside use and unknown requests
    always_comb begin
        o_entry.grp  = i_item.group_index;
        o_entry.data = i_item.intensity;
        o_entry.op   = mnf_pkg::OP_LOAD;
        o_push       = 1'b0;
        case (i_item.req_type)
            mnf_pkg::REQ_LOAD: begin
                o_entry.op = mnf_pkg::OP_LOAD;
                o_push     = w_take && ({1'b0, i_item.group_index} < w_ng);
            end
            mnf_pkg::REQ_COMPUTE: begin
                o_entry.op = mnf_pkg::OP_COMPUTE;
                o_push     = w_take;
            end
            mnf_pkg::REQ_SCALE: begin
                o_entry.op = mnf_pkg::OP_SCALE;
                o_push     = w_take;
            end
            default: o_push = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mnf_div.sv =====
// Module: restoring divider, one quotient bit per cycle.
`default_nettype none
module mnf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mnf_pkg::t_div_req i_req,
    output mnf_pkg::t_div_rsp      o_rsp
);

    localparam int SW = $clog2(mnf_pkg::DIVW + 1);

    logic [31:0]              r_rem;
    logic [31:0]              r_dvs;
    logic [mnf_pkg::DIVW-1:0] r_quo;
    logic [SW-1:0]            r_steps;
    logic                     r_busy, r_done;
    logic [32:0]              w_trial;
    logic                     w_fit;

    assign w_trial = {r_rem, r_quo[mnf_pkg::DIVW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    // shift in one dividend bit and try the subtract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= SW'(mnf_pkg::DIVW);
                r_rem   <= '0;
                r_quo   <= i_req.dividend;
                r_dvs   <= i_req.divisor;
            end else if (r_busy) begin
                r_rem   <= w_fit ? 32'(w_trial - {1'b0, r_dvs}) : w_trial[31:0];
                r_quo   <= {r_quo[mnf_pkg::DIVW-2:0], w_fit};
                r_steps <= r_steps - 1'b1;
                if (r_steps == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

// ===== hw/rtl/mnf_back.sv =====
// Module: back end: sample store, median selection, factor and scale results.
`default_nettype none
module mnf_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mnf_pkg::t_cfg     i_cfg,
    input  wire logic              i_q_empty,
    input  wire mnf_pkg::t_qentry  i_entry,
    output logic                   o_pop,
    output mnf_pkg::t_div_req      o_div,
    input  wire mnf_pkg::t_div_rsp i_div,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mnf_pkg::t_out_item     o_item
);

    localparam int GW  = mnf_pkg::GW;
    localparam int NGW = mnf_pkg::NGW;
    localparam int CW  = mnf_pkg::CW;
    localparam int IW  = mnf_pkg::IW;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCALE  = 9'b000000010,
        S_MSTART = 9'b000000100,
        S_SEL    = 9'b000001000,
        S_REF    = 9'b000010000,
        S_FSTART = 9'b000100000,
        S_FDIV   = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_DRAIN  = 9'b100000000
    } t_state;

    t_state r_state;

    logic [31:0]   r_store [mnf_pkg::MAX_GROUPS * mnf_pkg::SAMPLES_PER_GROUP];
    logic [31:0]   r_rdata;
    logic [CW-1:0] r_count [mnf_pkg::MAX_GROUPS];
    logic          r_drop  [mnf_pkg::MAX_GROUPS];
    logic [31:0]   r_med   [mnf_pkg::MAX_GROUPS];
    logic [31:0]   r_fact  [mnf_pkg::MAX_GROUPS];

    logic [NGW-1:0] r_g;
    logic [CW-1:0]  r_n, r_issue, r_k, r_cnt;
    logic           r_dv, r_second;
    logic [4:0]     r_bit;
    logic [31:0]    r_pfx, r_hmask, r_lo, r_refmed, r_fac;
    logic [1:0]     r_st;
    logic [63:0]    r_prod;
    logic [GW-1:0]  r_sgrp;
    logic           r_out_valid;
    mnf_pkg::t_out_item r_out;

    logic          w_out_free, w_load, w_issue, w_match, w_pass_done, w_bitset;
    logic [GW-1:0] w_gi, w_cidx, w_midx;
    logic [CW-1:0] w_cur_cnt;
    logic [31:0]   w_pfx_new, w_med_sel;
    logic [32:0]   w_sum;
    logic [47:0]   w_scaled;
    logic          w_last;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_gi       = r_g[GW-1:0];
    assign w_cidx     = r_state[0] ? i_entry.grp : w_gi;
    assign w_cur_cnt  = r_count[w_cidx];
    assign w_midx     = r_state[4] ? i_cfg.ref_grp : w_gi;
    assign w_med_sel  = r_med[w_midx];
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign w_load     = o_pop && (i_entry.op == mnf_pkg::OP_LOAD)
                        && (w_cur_cnt != CW'(mnf_pkg::SAMPLES_PER_GROUP));
    assign w_issue    = (r_state == S_SEL) && (r_issue != r_n);
    assign w_match    = (((r_rdata ^ r_pfx) & r_hmask) == 32'd0) && !r_rdata[r_bit];
    assign w_pass_done = (r_state == S_SEL) && (r_issue == r_n) && !r_dv;
    assign w_bitset   = !(r_k < r_cnt);
    assign w_pfx_new  = r_pfx | (32'(w_bitset) << r_bit);
    assign w_sum      = {1'b0, r_lo} + {1'b0, w_pfx_new};
    assign w_scaled   = r_prod[63:16];
    assign w_last     = (r_g == i_cfg.ng - 1'b1);

    // sample store: one write port for loads, one registered read port for selection
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_store[{i_entry.grp, w_cur_cnt[IW-1:0]}] <= i_entry.data;
        end
        if (w_issue) begin
            r_rdata <= r_store[{w_gi, r_issue[IW-1:0]}];
        end
    end

    assign o_div.start    = (r_state == S_FSTART) && (r_refmed != 32'd0)
                            && (w_med_sel != 32'd0);
    assign o_div.dividend = {r_refmed, 16'd0};
    assign o_div.divisor  = w_med_sel;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_g         <= '0;
            r_dv        <= 1'b0;
            for (int i = 0; i < mnf_pkg::MAX_GROUPS; i++) begin
                r_count[i] <= '0;
                r_drop[i]  <= 1'b0;
                r_med[i]   <= '0;
                r_fact[i]  <= '0;
            end
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_entry.op)
                            mnf_pkg::OP_LOAD: begin
                                if (w_load) r_count[i_entry.grp] <= w_cur_cnt + 1'b1;
                                else        r_drop[i_entry.grp]  <= 1'b1;
                            end
                            mnf_pkg::OP_SCALE: begin
                                r_prod  <= 64'(i_entry.data) * 64'(r_fact[i_entry.grp]);
                                r_sgrp  <= i_entry.grp;
                                r_state <= S_SCALE;
                            end
                            mnf_pkg::OP_COMPUTE: begin
                                r_g     <= '0;
                                r_state <= S_MSTART;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCALE: begin
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out.kind      <= mnf_pkg::KIND_SCALE;
                        r_out.out_group <= r_sgrp;
                        r_out.last      <= 1'b0;
                        if (w_scaled[47:32] != 16'd0) begin
                            r_out.value  <= 32'hFFFF_FFFF;
                            r_out.status <= mnf_pkg::ST_SAT;
                        end else begin
                            r_out.value  <= w_scaled[31:0];
                            r_out.status <= mnf_pkg::ST_OK;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MSTART: begin
                    if (r_g == i_cfg.ng) begin
                        r_state <= S_REF;
                    end else if (w_cur_cnt == '0) begin
                        r_med[w_gi] <= '0;
                        r_g         <= r_g + 1'b1;
                    end else begin
                        r_n      <= w_cur_cnt;
                        r_k      <= (w_cur_cnt - 1'b1) >> 1;
                        r_second <= 1'b0;
                        r_pfx    <= '0;
                        r_hmask  <= '0;
                        r_bit    <= 5'd31;
                        r_issue  <= '0;
                        r_cnt    <= '0;
                        r_dv     <= 1'b0;
                        r_state  <= S_SEL;
                    end
                end
                S_SEL: begin
                    // stream the group's samples; count those below the candidate bit
                    r_dv <= w_issue;
                    if (w_issue) r_issue <= r_issue + 1'b1;
                    if (r_dv && w_match) r_cnt <= r_cnt + 1'b1;
                    if (w_pass_done) begin
                        r_issue <= '0;
                        r_cnt   <= '0;
                        if (r_bit == 5'd0) begin
                            if (!r_second && !r_n[0]) begin
                                r_lo     <= w_pfx_new;
                                r_second <= 1'b1;
                                r_k      <= r_n >> 1;
                                r_pfx    <= '0;
                                r_hmask  <= '0;
                                r_bit    <= 5'd31;
                            end else begin
                                r_med[w_gi] <= r_second ? w_sum[32:1] : w_pfx_new;
                                r_g         <= r_g + 1'b1;
                                r_state     <= S_MSTART;
                            end
                        end else begin
                            r_pfx   <= w_pfx_new;
                            r_k     <= w_bitset ? r_k - r_cnt : r_k;
                            r_hmask <= r_hmask | (32'd1 << r_bit);
                            r_bit   <= r_bit - 1'b1;
                        end
                    end
                end
                S_REF: begin
                    r_refmed <= ({1'b0, i_cfg.ref_grp} < i_cfg.ng) ? w_med_sel : 32'd0;
                    r_g      <= '0;
                    r_state  <= S_FSTART;
                end
                S_FSTART: begin
                    if (o_div.start) begin
                        r_state <= S_FDIV;
                    end else begin
                        r_fac   <= '0;
                        r_st    <= mnf_pkg::ST_NOMED;
                        r_state <= S_EMIT;
                    end
                end
                S_FDIV: begin
                    if (i_div.done) begin
                        if (i_div.quotient[47:32] != 16'd0) begin
                            r_fac <= 32'hFFFF_FFFF;
                            r_st  <= mnf_pkg::ST_SAT;
                        end else begin
                            r_fac <= i_div.quotient[31:0];
                            r_st  <= mnf_pkg::ST_OK;
                        end
                        if (r_drop[w_gi]) r_st <= mnf_pkg::ST_DROP;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out.kind      <= mnf_pkg::KIND_FACTOR;
                        r_out.out_group <= w_gi;
                        r_out.value     <= r_fac;
                        r_out.status    <= r_st;
                        r_out.last      <= w_last;
                        r_fact[w_gi]    <= r_fac;
                        r_g             <= r_g + 1'b1;
                        r_state         <= w_last ? S_DRAIN : S_FSTART;
                    end
                end
                S_DRAIN: begin
                    // clear counts and flags; zero factors and medians of groups not in use
                    for (int i = 0; i < mnf_pkg::MAX_GROUPS; i++) begin
                        r_count[i] <= '0;
                        r_drop[i]  <= 1'b0;
                        if (NGW'(i) >= i_cfg.ng) begin
                            r_fact[i] <= '0;
                            r_med[i]  <= '0;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/median_normalization_factors.sv =====
// Top level: median normalization factors, front end, queue, divider and back end.
// Load: each transfer is queued, then written to the sample store; one load per cycle sustained while idle.
// Scale: the product is registered on the pop, then saturated into the result register; no new request is taken first.
// Compute: per group with n samples, a selection of 32 passes over its samples (two selections when n
//   is even), then a factor per group from the bit-serial divider.
// Reset is synchronous, active low: clears counts, drop flags, medians, factors and control;
//   the sample store is not cleared and needs no clearing pass.
`default_nettype none
module median_normalization_factors (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [3:0]        i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire mnf_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mnf_pkg::t_out_item     o_item
);

    logic              w_push, w_full, w_pop, w_empty;
    mnf_pkg::t_qentry  w_in_entry, w_out_entry;
    mnf_pkg::t_cfg     w_cfg;
    mnf_pkg::t_div_req w_div_req;
    mnf_pkg::t_div_rsp w_div_rsp;

    mnf_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_item,
        .i_q_full(w_full), .o_push(w_push), .o_entry(w_in_entry), .o_cfg(w_cfg)
    );

    mnf_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_entry(w_in_entry), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_entry(w_out_entry)
    );

    mnf_div u_div (
        .i_clk, .i_rst_n, .i_req(w_div_req), .o_rsp(w_div_rsp)
    );

    mnf_back u_back (
        .i_clk, .i_rst_n, .i_cfg(w_cfg),
        .i_q_empty(w_empty), .i_entry(w_out_entry), .o_pop(w_pop),
        .o_div(w_div_req), .i_div(w_div_rsp),
        .o_valid, .i_ready, .o_item
    );

endmodule
`default_nettype wire

// ===== hw/rtl/mnf_checker.sv =====
// Checker: port-level assertions for median normalization factors, bound to the top level.
`default_nettype none
module mnf_port_checks (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               o_ready,
    input  wire mnf_pkg::t_in_item  i_item,
    input  wire logic               o_valid,
    input  wire logic               i_ready,
    input  wire mnf_pkg::t_out_item o_item
);

    // hold a waiting input item
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_item))
        else $error("input item changed while waiting");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    // scaled results never close a compute run
    a_scale_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.kind == mnf_pkg::KIND_SCALE |-> !o_item.last)
        else $error("scaled result marked last");

    // no valid median gives a zero factor
    a_nomed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == mnf_pkg::ST_NOMED |-> o_item.value == 32'd0)
        else $error("nonzero factor without median");

    // saturation pins the value at all ones
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == mnf_pkg::ST_SAT |-> o_item.value == 32'hFFFF_FFFF)
        else $error("saturated value not at maximum");

endmodule

bind median_normalization_factors mnf_port_checks u_chk (.*);
`default_nettype wire

// ===== tb/sv/mnf_checker.sv =====
// Checker: predicts median normalization results from observed transfers and compares them.
`default_nettype none
module mnf_checker
    import mnf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [3:0] i_cfg_data,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out_item,
    output int             o_errors,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted block state
    logic [3:0]  groups_reg;
    logic [2:0]  ref_reg;
    logic [31:0] samples [MAX_GROUPS][SAMPLES_PER_GROUP];
    int          fill    [MAX_GROUPS];
    logic        dropped [MAX_GROUPS];
    logic [31:0] factors [MAX_GROUPS];
    t_out_item   awaited[$];
    int          mismatches;

    assign o_errors  = mismatches;

    // clamp the group register to the range the block honors
    function automatic int groups_active();
        if (groups_reg == 0) return 1;
        if (groups_reg > MAX_GROUPS) return MAX_GROUPS;
        return int'(groups_reg);
    endfunction

    function automatic logic [31:0] median_of(int g);
        logic [31:0] vals[$];
        int n;
        logic [32:0] sum;
        n = fill[g];
        if (n == 0) return 32'd0;
        for (int i = 0; i < n; i++) vals = {vals, samples[g][i]};
        vals.sort();
        if (n % 2 == 1) return vals[n / 2];
        sum = {1'b0, vals[n / 2 - 1]} + {1'b0, vals[n / 2]};
        return sum[32:1];
    endfunction

    // work out the factor run and clear the stores
    task automatic predict_factors();
        logic [31:0] med [MAX_GROUPS];
        logic [63:0] q;
        logic        ref_ok;
        int          ng;
        t_out_item   r;
        ng = groups_active();
        for (int g = 0; g < MAX_GROUPS; g++) med[g] = (g < ng) ? median_of(g) : 32'd0;
        ref_ok = (int'(ref_reg) < ng) && (med[ref_reg] != 0);
        for (int g = 0; g < MAX_GROUPS; g++) begin
            factors[g] = 32'd0;
            if (g < ng) begin
                r.kind = KIND_FACTOR;
                r.out_group = g[2:0];
                r.last = (g == ng - 1);
                if (!ref_ok || med[g] == 0) begin
                    r.status = ST_NOMED;
                end else begin
                    q = {med[ref_reg], 16'd0} / {32'd0, med[g]};
                    r.status = ST_OK;
                    if (q > 64'hFFFF_FFFF) begin
                        q = 64'hFFFF_FFFF;
                        r.status = ST_SAT;
                    end
                    factors[g] = q[31:0];
                    if (dropped[g]) r.status = ST_DROP;
                end
                r.value = factors[g];
                awaited = {awaited, r};
            end
        end
        for (int g = 0; g < MAX_GROUPS; g++) begin
            fill[g] = 0;
            dropped[g] = 1'b0;
        end
    endtask

    task automatic predict_item(t_in_item it);
        t_out_item   r;
        logic [63:0] p;
        int          g;
        g = int'(it.group_index);
        case (it.req_type)
            REQ_LOAD: begin
                if (g < groups_active()) begin
                    if (fill[g] >= SAMPLES_PER_GROUP) begin
                        dropped[g] = 1'b1;
                    end else begin
                        samples[g][fill[g]] = it.intensity;
                        fill[g]++;
                    end
                end
            end
            REQ_COMPUTE: predict_factors();
            REQ_SCALE: begin
                p = ({32'd0, it.intensity} * {32'd0, factors[g]}) >> 16;
                r.kind = KIND_SCALE;
                r.out_group = it.group_index;
                r.status = ST_OK;
                r.last = 1'b0;
                if (p > 64'hFFFF_FFFF) begin
                    p = 64'hFFFF_FFFF;
                    r.status = ST_SAT;
                end
                r.value = p[31:0];
                awaited = {awaited, r};
            end
            default: ;
        endcase
    endtask

    // follow register writes and transfers, compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            groups_reg <= 4'd8;
            ref_reg <= 3'd0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                fill[g] = 0;
                dropped[g] = 1'b0;
                factors[g] = 32'd0;
            end
            awaited.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GROUPS) groups_reg <= i_cfg_data;
                else if (i_cfg_idx == CFG_REF) ref_reg <= i_cfg_data[2:0];
            end
            if (i_in_valid && i_in_ready) predict_item(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result %p", $realtime, i_out_item);
                    mismatches++;
                end else begin
                    if (i_out_item !== awaited[0]) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, awaited[0], i_out_item);
                        mismatches++;
                    end
                    void'(awaited.pop_front());
                end
            end
        end
        o_pending <= awaited.size();
    end

    initial mismatches = 0;
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench top: clock, reset, stimulus, output stalls, watchdog and verdict.
`default_nettype none
module tb;
    import mnf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int IDLE_LIMIT = 400000;
    localparam int SETTLE = 40;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [1:0] cfg_idx;
    logic [3:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        errors;
    int        pending;
    int        idle_cycles;
    int        burst_left;

    median_normalization_factors i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_item(in_item),
        .o_valid(out_valid), .i_ready(out_ready), .o_item(out_item)
    );

    mnf_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // stall the result side: always ready, random, or long stalls
    initial begin
        int mode;
        int span;
        out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // hold the item until the transfer, leave valid high on return
    task automatic send(logic [1:0] req, logic [2:0] grp, logic [31:0] inten);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_item <= '{req_type: req, group_index: grp, intensity: inten};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // drop valid and let all results and any trailing store writes land
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_intensity();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1000);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int ng;
        int roll;
        logic [2:0] grp;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_GROUPS;
        cfg_data = 4'd0;
        in_valid = 1'b0;
        in_item = '0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: factor never computed, unknown request, edge medians
        send(REQ_SCALE, 3'd0, 32'hFFFF_FFFF);
        send(REQ_UNKNOWN, 3'd7, 32'hFFFF_FFFF);
        send(REQ_LOAD, 3'd0, 32'hFFFF_FFFF);
        send(REQ_LOAD, 3'd0, 32'hFFFF_FFFE);
        send(REQ_LOAD, 3'd1, 32'd1);
        send(REQ_LOAD, 3'd2, 32'd0);
        send(REQ_LOAD, 3'd3, 32'd5);
        send(REQ_LOAD, 3'd3, 32'd7);
        send(REQ_LOAD, 3'd3, 32'd6);
        send(REQ_LOAD, 3'd7, 32'h0001_0000);
        send(REQ_COMPUTE, 3'd0, 32'd0);
        send(REQ_SCALE, 3'd1, 32'hFFFF_FFFF);
        send(REQ_SCALE, 3'd3, 32'd0);
        send(REQ_SCALE, 3'd4, 32'h1234_5678);
        send(REQ_SCALE, 3'd7, 32'h8000_0000);
        drain();

        // one group in use via a zero count, reference not in use, load outside use
        write_reg(CFG_GROUPS, 4'd0);
        write_reg(CFG_REF, 4'd3);
        send(REQ_LOAD, 3'd0, 32'd100);
        send(REQ_LOAD, 3'd5, 32'd100);
        send(REQ_COMPUTE, 3'd5, 32'd0);
        drain();

        // random phases over register settings, extremes first
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_GROUPS, 4'd15); write_reg(CFG_REF, 4'd7); end
                1: begin write_reg(CFG_GROUPS, 4'd1); write_reg(CFG_REF, 4'd0); end
                2: begin write_reg(CFG_GROUPS, 4'd8); write_reg(CFG_REF, 4'd0); end
                default: begin
                    write_reg(CFG_GROUPS, 4'($urandom_range(0, 15)));
                    write_reg(CFG_REF, 4'($urandom_range(0, 7)));
                end
            endcase
            ng = i_checker.groups_active();
            for (int k = 0; k < 23; k++) begin
                roll = $urandom_range(0, 99);
                grp = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(0, ng - 1));
                if (roll < 60) send(REQ_LOAD, grp, pick_intensity());
                else if (roll < 70) send(REQ_COMPUTE, grp, $urandom);
                else if (roll < 95) send(REQ_SCALE, 3'($urandom_range(0, 7)), pick_intensity());
                else send(REQ_UNKNOWN, grp, $urandom);
            end
            send(REQ_COMPUTE, 3'd0, 32'd0);
            send(REQ_SCALE, 3'($urandom_range(0, 7)), $urandom);
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== median_normalization_factors.f =====
hw/rtl/mnf_pkg.sv
hw/rtl/mnf_queue.sv
hw/rtl/mnf_front.sv
hw/rtl/mnf_div.sv
hw/rtl/mnf_back.sv
hw/rtl/median_normalization_factors.sv
hw/rtl/mnf_checker.sv
tb/sv/mnf_checker.sv
tb/sv/tb.sv
